>>> rtl/rtc_pkg.sv
// Shared types, constants and calendar helpers for the real-time clock calendar.
package rtc_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int ACTION_W = 2;

    // Action codes carried on the slave-side tuser.
    localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_DATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_TIME = 2'd2;

    localparam logic [YEAR_W-1:0]   YEAR_MAX      = 14'd9999;
    localparam logic [YEAR_W-1:0]   YEAR_MIN      = 14'd1;
    localparam logic [MONTH_W-1:0]  MONTH_LAST    = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_LAST     = 5'd23;
    localparam logic [HOUR_W-1:0]   HOUR_NOON     = 5'd12;
    localparam logic [HOUR_W-1:0]   HOUR_MIDNIGHT = 5'd0;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST   = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_LAST   = 6'd59;

    localparam logic [YEAR_W-1:0]   RST_YEAR      = 14'd2016;
    localparam logic [MONTH_W-1:0]  RST_MONTH     = 4'd2;
    localparam logic [DAY_W-1:0]    RST_DAY       = 5'd29;
    localparam logic [HOUR_W-1:0]   RST_HOUR      = 5'd0;
    localparam logic [MINUTE_W-1:0] RST_MINUTE    = 6'd59;
    localparam logic [SECOND_W-1:0] RST_SECOND    = 6'd55;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y.
    localparam int          RECIP_W     = 13;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W      = YEAR_W + RECIP_W;
    localparam int          CENT_W      = 8;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_req;

    typedef struct packed {
        logic                ok;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [HOUR_W-1:0]   shown_hour;
        logic                is_pm;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_rsp;

    // Gregorian leap rule; the century test uses a reciprocal multiply.
    function automatic logic f_is_leap(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [CENT_W-1:0] cent;
        logic [YEAR_W-1:0] cent_x100;
        logic              div100;
        prod      = PROD_W'(y) * PROD_W'(RECIP_100);
        cent      = prod[PROD_W-1:RECIP_SHIFT];
        cent_x100 = YEAR_W'({cent, 6'b0}) + YEAR_W'({cent, 5'b0}) + YEAR_W'({cent, 2'b0});
        div100    = (cent_x100 == y);
        return div100 ? (cent[1:0] == 2'b00) : (y[1:0] == 2'b00);
    endfunction

    // Length of a month; codes outside 1..12 give zero.
    function automatic logic [DAY_W-1:0] f_days_in(input logic [MONTH_W-1:0] m,
                                                   input logic              leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/rtc_in_reg.sv
// Input register stage: holds one accepted request until the core consumes it.
module rtc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rtc_pkg::t_req i_req,
    input  logic          i_take,
    output logic          o_valid,
    output rtc_pkg::t_req o_req
);
    import rtc_pkg::*;

    logic r_vld;
    t_req r_req;

    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

>>> rtl/rtc_core.sv
// Clock and calendar state with tick rollover, load checks and hour formatting.
module rtc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  rtc_pkg::t_req i_req,
    input  logic          i_civil_mode,
    output rtc_pkg::t_rsp o_rsp
);
    import rtc_pkg::*;

    logic [YEAR_W-1:0]   r_year,   n_year;
    logic [MONTH_W-1:0]  r_month,  n_month;
    logic [DAY_W-1:0]    r_day,    n_day;
    logic [HOUR_W-1:0]   r_hour,   n_hour;
    logic [MINUTE_W-1:0] r_minute, n_minute;
    logic [SECOND_W-1:0] r_second, n_second;

    logic             leap_now;
    logic [DAY_W-1:0] dim_now;
    logic             leap_load;
    logic [DAY_W-1:0] dim_load;
    logic             sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    logic             date_ok, time_ok;
    logic             ok;

    assign leap_now  = f_is_leap(r_year);
    assign dim_now   = f_days_in(r_month, leap_now);
    assign leap_load = f_is_leap(i_req.year);
    assign dim_load  = f_days_in(i_req.month, leap_load);

    // Carry chain of a one-second tick.
    assign sec_wrap   = (r_second >= SECOND_LAST);
    assign min_wrap   = sec_wrap  && (r_minute >= MINUTE_LAST);
    assign hour_wrap  = min_wrap  && (r_hour >= HOUR_LAST);
    assign day_wrap   = hour_wrap && (r_day >= dim_now);
    assign month_wrap = day_wrap  && (r_month >= MONTH_LAST);

    assign date_ok = (i_req.month != '0) && (i_req.month <= MONTH_LAST)
                  && (i_req.year >= YEAR_MIN) && (i_req.year <= YEAR_MAX)
                  && (i_req.day != '0) && (i_req.day <= dim_load);
    assign time_ok = (i_req.hour <= HOUR_LAST) && (i_req.minute <= MINUTE_LAST)
                  && (i_req.second <= SECOND_LAST);

    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        ok       = 1'b0;
        unique case (i_req.action)
            ACT_TICK: begin
                ok       = 1'b1;
                n_second = sec_wrap ? '0 : r_second + 1'b1;
                if (sec_wrap) begin
                    n_minute = min_wrap ? '0 : r_minute + 1'b1;
                end
                if (min_wrap) begin
                    n_hour = hour_wrap ? '0 : r_hour + 1'b1;
                end
                if (hour_wrap) begin
                    n_day = day_wrap ? DAY_W'(1) : r_day + 1'b1;
                end
                if (day_wrap) begin
                    n_month = month_wrap ? MONTH_W'(1) : r_month + 1'b1;
                end
                if (month_wrap) begin
                    n_year = (r_year >= YEAR_MAX) ? YEAR_MIN : r_year + 1'b1;
                end
            end
            ACT_LOAD_DATE: begin
                ok = date_ok;
                if (date_ok) begin
                    n_year  = i_req.year;
                    n_month = i_req.month;
                    n_day   = i_req.day;
                end
            end
            ACT_LOAD_TIME: begin
                ok = time_ok;
                if (time_ok) begin
                    n_hour   = i_req.hour;
                    n_minute = i_req.minute;
                    n_second = i_req.second;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_rsp.ok     = ok;
        o_rsp.year   = n_year;
        o_rsp.month  = n_month;
        o_rsp.day    = n_day;
        o_rsp.hour   = n_hour;
        o_rsp.minute = n_minute;
        o_rsp.second = n_second;
        o_rsp.is_pm  = (n_hour >= HOUR_NOON);
        if (!i_civil_mode) begin
            o_rsp.shown_hour = n_hour;
        end else if (n_hour == HOUR_MIDNIGHT) begin
            o_rsp.shown_hour = HOUR_NOON;
        end else if (n_hour > HOUR_NOON) begin
            o_rsp.shown_hour = n_hour - HOUR_NOON;
        end else begin
            o_rsp.shown_hour = n_hour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= RST_YEAR;
            r_month  <= RST_MONTH;
            r_day    <= RST_DAY;
            r_hour   <= RST_HOUR;
            r_minute <= RST_MINUTE;
            r_second <= RST_SECOND;
        end else if (i_step) begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    // The stored time and date always form a legal calendar moment.
    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month != '0) && (r_month <= MONTH_LAST) && (r_day != '0)
        && (r_day <= dim_now) && (r_year != '0) && (r_year <= YEAR_MAX)
        && (r_hour <= HOUR_LAST) && (r_minute <= MINUTE_LAST)
        && (r_second <= SECOND_LAST))
        else $error("calendar state out of range");

    // A refused request leaves the clock untouched.
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !ok |=> $stable({r_year, r_month, r_day, r_hour, r_minute, r_second}))
        else $error("rejected request changed state");

    // A tick inside a minute only advances the seconds.
    a_tick_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_req.action == ACT_TICK) && !sec_wrap
        |=> (r_second == $past(r_second) + 1'b1) && (r_minute == $past(r_minute)))
        else $error("tick did not advance seconds");

    // Every tick is accepted.
    a_tick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_req.action == ACT_TICK) |-> ok)
        else $error("tick not flagged ok");

endmodule

>>> rtl/rtc_out_reg.sv
// Result register stage: holds one result until the downstream side takes it.
module rtc_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  rtc_pkg::t_rsp i_rsp,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output rtc_pkg::t_rsp o_rsp
);
    import rtc_pkg::*;

    logic r_vld;
    t_rsp r_rsp;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

>>> rtl/calendar_clock_with_leap_year_top.sv
// Top level of the real-time clock with Gregorian calendar and stream ports.
//
// Real-time clock and Gregorian calendar. Each request on the slave stream is a
// one-second tick, a date load or a time load (selected by s_axis_tuser); each
// request returns exactly one result on the master stream carrying the time and
// date after the request, an ok flag, and the hour as displayed. A request is
// taken every clock: it is held in the input register, and the calendar logic
// updates the state as it moves into the result register. The throughput is one
// request per cycle, limited only by downstream
// backpressure on m_axis_tready. Loads that fail their range check (month 1-12,
// year 1-9999, day within the month using the leap rule of the loaded year;
// time up to 23:59:59) change nothing and return ok = 0, as does action code 3.
// The year wraps from 9999 to 1. The display mode register (i_cfg_we,
// i_cfg_wdata) selects 12-hour display when 1 (its reset value) and 24-hour when
// 0; write it only while no request is in flight. Reset is synchronous, active
// low, and loads 2016-02-29 00:59:55.
module calendar_clock_with_leap_year_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Display mode register write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: in_day[4:0], in_month[8:5], in_year[22:9],
    // in_hour[27:23], in_minute[33:28], in_second[39:34]
    input  logic [39:0] s_axis_tdata,
    // tuser: action[1:0] (0 tick, 1 load date, 2 load time)
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: year_now[13:0], month_now[17:14], day_now[22:18],
    // hour_now[27:23], shown_hour[32:28], is_pm[33], minute_now[39:34],
    // second_now[45:40], zero pad [47:46]
    output logic [47:0] m_axis_tdata,
    // tuser: ok[0]
    output logic        m_axis_tuser
);
    import rtc_pkg::*;

    logic r_civil_mode;
    t_req in_req;
    t_req held_req;
    logic held_vld;
    logic out_free;
    logic step;
    t_rsp core_rsp;
    t_rsp out_rsp;

    // Unpack the request fields from the bus.
    always_comb begin
        in_req.action = s_axis_tuser;
        in_req.day    = s_axis_tdata[4:0];
        in_req.month  = s_axis_tdata[8:5];
        in_req.year   = s_axis_tdata[22:9];
        in_req.hour   = s_axis_tdata[27:23];
        in_req.minute = s_axis_tdata[33:28];
        in_req.second = s_axis_tdata[39:34];
    end

    // Hold the display mode; the user must write it only while idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_civil_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_civil_mode <= i_cfg_wdata;
        end
    end

    // Advance the calendar whenever the held request can move into the result slot.
    assign step = held_vld && out_free;

    rtc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (in_req),
        .i_take  (step),
        .o_valid (held_vld),
        .o_req   (held_req)
    );

    rtc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_req        (held_req),
        .i_civil_mode (r_civil_mode),
        .o_rsp        (core_rsp)
    );

    rtc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_rsp   (core_rsp),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rsp   (out_rsp)
    );

    // Pack the result onto the bus.
    assign m_axis_tuser = out_rsp.ok;
    assign m_axis_tdata = {2'b00, out_rsp.second, out_rsp.minute, out_rsp.is_pm,
                           out_rsp.shown_hour, out_rsp.hour, out_rsp.day,
                           out_rsp.month, out_rsp.year};

    // A stalled request port means the input register is full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> held_vld && m_axis_tvalid)
        else $error("request port stalled with room to spare");

    // Every step fills the result slot on the next edge.
    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("step did not produce a result");

    // In 24-hour display the shown hour is the hour itself.
    a_shown_24h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_civil_mode |-> m_axis_tdata[32:28] == m_axis_tdata[27:23]
        || $past(r_civil_mode))
        else $error("24-hour display differs from hour");

endmodule
